// ===== rtl/core/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg: shared types and constants of the preamble frame deframer
// Phase codes, event codes, CRC-16/MODBUS byte update and result word type.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam logic [7:0]  PreambleByte = 8'hAA;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [7:0]  MinHdrReset  = 8'd20;
  localparam logic [7:0]  MaxHdrReset  = 8'd30;
  localparam logic [7:0]  HdrLenFloor  = 8'd4;

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegMinHdr = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMaxHdr = CfgIdxW'(1);

  localparam logic [1:0] SeenHunt    = 2'd0;
  localparam logic [1:0] SeenHeader  = 2'd1;
  localparam logic [1:0] SeenPayload = 2'd2;
  localparam logic [1:0] SeenCrc     = 2'd3;

  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvPreamble = 3'd1;
  localparam logic [2:0] EvReject   = 3'd2;
  localparam logic [2:0] EvCrcPass  = 3'd3;
  localparam logic [2:0] EvCrcFail  = 3'd4;

  typedef enum logic [3:0] {
    PhHunt    = 4'b0001,
    PhHeader  = 4'b0010,
    PhPayload = 4'b0100,
    PhCrc     = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]  phase_seen;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_event;
    logic [15:0] payload_length;
    logic [15:0] crc_value;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/pfd_if.sv =====
// ----------------------------------------------------------------------------
// pfd_if: channel interfaces of the preamble frame deframer
// Input byte channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface pfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase_seen;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_event;
  logic [15:0] payload_length;
  logic [15:0] crc_value;
  modport source (output valid, output phase_seen, output payload_valid, output payload_byte,
                  output frame_event, output payload_length, output crc_value, input ready);
  modport sink (input valid, input phase_seen, input payload_valid, input payload_byte,
                input frame_event, input payload_length, input crc_value, output ready);
endinterface

interface pfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pfd_parser.sv =====
// ----------------------------------------------------------------------------
// pfd_parser: frame section tracker and running CRC
// Holds the deframing state and forms the result word of the byte presented.
// ----------------------------------------------------------------------------
module pfd_parser import pfd_pkg::*; #(
  parameter int unsigned PREAMBLE_LEN = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] min_hdr_i,
  input  logic [7:0] max_hdr_i,
  output res_t       res_o
);

  localparam int unsigned MatchW = $clog2(PREAMBLE_LEN + 1);

  phase_e            phase_q, phase_d;
  logic [MatchW-1:0] match_q, match_d;
  logic [7:0]        hdr_len_q, hdr_len_d;
  logic [15:0]       count_q, count_d;
  logic [15:0]       plen_q, plen_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic [7:0]        crc_hi_q, crc_hi_d;

  logic [MatchW:0] match_inc;
  logic [16:0]     count_inc;
  logic [7:0]      hdr_len_v;
  logic [15:0]     plen_v;
  logic [15:0]     crc_step;

  assign match_inc = {1'b0, match_q} + (MatchW+1)'(1);
  assign count_inc = {1'b0, count_q} + 17'd1;
  assign crc_step  = crc16_byte(crc_q, rx_byte_i);

  always_comb begin
    phase_d   = phase_q;
    match_d   = match_q;
    hdr_len_d = hdr_len_q;
    count_d   = count_q;
    plen_d    = plen_q;
    crc_d     = crc_q;
    len_hi_d  = len_hi_q;
    crc_hi_d  = crc_hi_q;
    hdr_len_v = hdr_len_q;
    plen_v    = plen_q;
    res_o     = '0;

    unique case (phase_q)
      PhHunt: begin
        res_o.phase_seen = SeenHunt;
        if (rx_byte_i == PreambleByte) begin
          crc_d = crc_step;
          if (match_inc >= (MatchW+1)'(PREAMBLE_LEN)) begin
            match_d           = '0;
            count_d           = '0;
            phase_d           = PhHeader;
            res_o.frame_event = EvPreamble;
          end else begin
            match_d = match_inc[MatchW-1:0];
          end
        end else begin
          match_d = '0;
          crc_d   = CrcInit;
        end
      end
      PhHeader: begin
        res_o.phase_seen = SeenHeader;
        if (count_q == 16'd0 && (rx_byte_i < HdrLenFloor || rx_byte_i < min_hdr_i ||
                                 rx_byte_i > max_hdr_i)) begin
          plen_d            = '0;
          len_hi_d          = '0;
          res_o.frame_event = EvReject;
          phase_d           = PhHunt;
          match_d           = '0;
          hdr_len_d         = '0;
          count_d           = '0;
          crc_d             = CrcInit;
          crc_hi_d          = '0;
        end else begin
          if (count_q == 16'd0) begin
            plen_v    = '0;
            len_hi_d  = '0;
            hdr_len_v = rx_byte_i;
          end else if (count_q == 16'd2) begin
            len_hi_d = rx_byte_i;
          end else if (count_q == 16'd3) begin
            plen_v = {len_hi_q, rx_byte_i};
          end
          plen_d    = plen_v;
          hdr_len_d = hdr_len_v;
          crc_d     = crc_step;
          count_d   = count_inc[15:0];
          if (count_inc >= {9'd0, hdr_len_v}) begin
            count_d = '0;
            phase_d = (plen_v == 16'd0) ? PhCrc : PhPayload;
          end
        end
      end
      PhPayload: begin
        res_o.phase_seen    = SeenPayload;
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = rx_byte_i;
        crc_d               = crc_step;
        count_d             = count_inc[15:0];
        if (count_inc >= {1'b0, plen_q}) begin
          count_d = '0;
          phase_d = PhCrc;
        end
      end
      PhCrc: begin
        res_o.phase_seen = SeenCrc;
        if (count_q == 16'd0) begin
          crc_hi_d = rx_byte_i;
          count_d  = 16'd1;
        end else begin
          res_o.crc_value   = crc_q;
          res_o.frame_event = ({crc_hi_q, rx_byte_i} == crc_q) ? EvCrcPass : EvCrcFail;
          phase_d           = PhHunt;
          match_d           = '0;
          hdr_len_d         = '0;
          count_d           = '0;
          crc_d             = CrcInit;
          crc_hi_d          = '0;
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase

    res_o.payload_length = plen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      match_q   <= '0;
      hdr_len_q <= '0;
      count_q   <= '0;
      plen_q    <= '0;
      crc_q     <= CrcInit;
      len_hi_q  <= '0;
      crc_hi_q  <= '0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      match_q   <= match_d;
      hdr_len_q <= hdr_len_d;
      count_q   <= count_d;
      plen_q    <= plen_d;
      crc_q     <= crc_d;
      len_hi_q  <= len_hi_d;
      crc_hi_q  <= crc_hi_d;
    end
  end

endmodule

// ===== rtl/core/preamble_frame_deframer_crc16.sv =====
// ----------------------------------------------------------------------------
// preamble_frame_deframer_crc16: byte-serial deframer with CRC-16/MODBUS check
//
//   channel  dir  payload                                   handshake
//   in_i     in   rx_byte                                   valid/ready
//   out_o    out  phase_seen, payload_valid, payload_byte,  valid/ready
//                 frame_event, payload_length, crc_value
//   cfg_i    in   index, data (0 min hdr len, 1 max)        valid/ready
//
// One word a cycle: the section tracker and a byte-wide CRC update sit between
// the state registers and the result register, so a word is taken every cycle.
// The result shows in the cycle after acceptance and holds while out_o stalls;
// input is taken while the result register is empty or being drained.
// Reset returns to preamble hunt with CRC 0xFFFF and header bounds 20..30.
// ----------------------------------------------------------------------------
module preamble_frame_deframer_crc16 import pfd_pkg::*; #(
  parameter int unsigned PREAMBLE_LEN = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfd_in_if.sink     in_i,
  pfd_out_if.source  out_o,
  pfd_cfg_if.sink    cfg_i
);

  logic [7:0] min_hdr_q, max_hdr_q;
  logic       out_valid_q;
  res_t       res_d, res_q;
  logic       in_accept;

  assign in_i.ready  = ~out_valid_q | out_o.ready;
  assign in_accept   = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_hdr_q <= MinHdrReset;
      max_hdr_q <= MaxHdrReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegMinHdr) begin
        min_hdr_q <= cfg_i.data;
      end else if (cfg_i.index == RegMaxHdr) begin
        max_hdr_q <= cfg_i.data;
      end
    end
  end

  pfd_parser #(
    .PREAMBLE_LEN (PREAMBLE_LEN)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_accept),
    .rx_byte_i (in_i.rx_byte),
    .min_hdr_i (min_hdr_q),
    .max_hdr_i (max_hdr_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.phase_seen     = res_q.phase_seen;
  assign out_o.payload_valid  = res_q.payload_valid;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.frame_event    = res_q.frame_event;
  assign out_o.payload_length = res_q.payload_length;
  assign out_o.crc_value      = res_q.crc_value;

endmodule

// ===== rtl/core/pfd_checker.sv =====
// ----------------------------------------------------------------------------
// pfd_checker: port-level checks of the deframer result stream
// Ties events and payload flags to the section that consumed the word.
// ----------------------------------------------------------------------------
module pfd_checker import pfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  phase_seen,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic [2:0]  frame_event,
  input logic [15:0] crc_value
);

  a_payload_section: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && payload_valid |-> phase_seen == SeenPayload)
    else $error("payload word outside payload section");

  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !payload_valid |-> payload_byte == 8'd0 && phase_seen != SeenPayload)
    else $error("payload byte or section without payload flag");

  a_verdict_section: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (frame_event == EvCrcPass || frame_event == EvCrcFail)
      |-> phase_seen == SeenCrc)
    else $error("crc verdict outside crc section");

  a_crc_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && frame_event != EvCrcPass && frame_event != EvCrcFail
      |-> crc_value == 16'd0)
    else $error("crc value shown without verdict");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(frame_event) && $stable(payload_byte))
    else $error("stalled result word changed");

endmodule

bind preamble_frame_deframer_crc16 pfd_checker u_pfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .phase_seen    (out_o.phase_seen),
  .payload_valid (out_o.payload_valid),
  .payload_byte  (out_o.payload_byte),
  .frame_event   (out_o.frame_event),
  .crc_value     (out_o.crc_value)
);
